/* hdl/i2a_pkg.sv */
// Package for the integer-to-ASCII formatter: sizes, command codes,
// character constants, controller states and the control/status structs.
// No dependencies; compile first.
package i2a_pkg;

  localparam int DIGIT_BUFFER_DEPTH = 16;
  localparam int WIDTH_LIMIT        = 63;

  localparam int IDX_W   = $clog2(DIGIT_BUFFER_DEPTH);
  localparam int EXT_W   = 4 * DIGIT_BUFFER_DEPTH;
  localparam int LEN_W   = 7;
  localparam int ITER_W  = 5;

  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_HEXL = 3'd2;
  localparam logic [2:0] CMD_HEXU = 3'd3;
  localparam logic [2:0] CMD_OCT  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_SIGN_A,
    ST_PAD,
    ST_SIGN_B,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic count;
    logic emit_sign;
    logic emit_pad;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic iter_last;
    logic neg;
    logic zf;
    logic pad_zero;
    logic pad_last;
    logic digit_last;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/i2a_in_if.sv */
// Input channel of the formatter: one conversion request per beat.
// Depends on nothing.
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  cmd;
  logic        zero_fill;
  logic [5:0]  pad_width;

  modport source (output valid, value, cmd, zero_fill, pad_width, input ready);
  modport sink   (input valid, value, cmd, zero_fill, pad_width, output ready);
endinterface

/* hdl/i2a_out_if.sv */
// Output channel of the formatter: one ASCII character per beat.
// Depends on nothing.
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

/* hdl/integer_to_ascii_formatter_top.sv */
// Top level of the integer-to-ASCII formatter.
// Depends on i2a_pkg, i2a_in_if, i2a_out_if, i2a_ctrl and i2a_datapath.
//
// Usage:
//   item : one beat per conversion (value, cmd, zero_fill, pad_width).
//          cmd 0 signed decimal, 1 unsigned decimal, 2 hex lower,
//          3 hex upper, 4 octal; 5..7 act as unsigned decimal.
//   text : one ASCII character per beat, most significant digit first,
//          last high on the final character of the conversion.
//   Padding goes on the left up to pad_width (clamped to WIDTH_LIMIT);
//   with zero fill a minus sign stays leftmost, ahead of the zeros.
// Timing:
//   item.ready is high only while the controller is idle. A decimal item
//   runs the shift-add-3 loop over every bit of the value; hex and octal
//   items skip the loop. A count step then sizes the padding. Characters
//   leave one per cycle through the output register while text.ready is
//   high; when no padding is due, the pad state passes without sending one.
// Reset (rst, synchronous) returns the controller to idle and drops any
// pending character beat. When text.ready is low the current character
// holds in the output register and the character sequencer waits.
module integer_to_ascii_formatter_top (
  input logic       clk,
  input logic       rst,
  i2a_in_if.sink    item,
  i2a_out_if.source text
);
  import i2a_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t status;
  logic       item_ready;

  assign item.ready = item_ready;

  // Sequencer
  i2a_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .status     (status),
    .ctl        (ctl)
  );

  // Conversion datapath and output register
  i2a_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (item.value),
    .cmd       (item.cmd),
    .zero_fill (item.zero_fill),
    .pad_width (item.pad_width),
    .ctl       (ctl),
    .status    (status),
    .text      (text)
  );

  // Accepting a request leaves idle, so the next request must wait.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("request taken while a conversion was under way");

  // A character is only written into a free output register.
  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit_sign || ctl.emit_pad || ctl.emit_digit) |-> status.out_free)
    else $error("character written over a pending beat");

  // At most one character source per cycle.
  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.emit_sign, ctl.emit_pad, ctl.emit_digit}))
    else $error("several character sources in one cycle");

  // A new request is never loaded while characters are being produced.
  a_no_load_mid_text: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !(ctl.emit_sign || ctl.emit_pad || ctl.emit_digit || ctl.dabble))
    else $error("load overlapped with conversion work");

endmodule

/* hdl/i2a_datapath.sv */
// Datapath: operand registers, digit buffer with shift-add-3 conversion,
// pad and digit counters, and the output character register.
// Depends on i2a_pkg and i2a_out_if.
module i2a_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         value,
  input  logic [2:0]          cmd,
  input  logic                zero_fill,
  input  logic [5:0]          pad_width,
  input  i2a_pkg::ctrl_cmd_t  ctl,
  output i2a_pkg::dp_status_t status,
  i2a_out_if.source           text
);
  import i2a_pkg::*;

  logic [31:0]      mag;
  logic             is_dec;
  logic             upper;
  logic             neg;
  logic             zf;
  logic [5:0]       width;
  logic [3:0]       digits [DIGIT_BUFFER_DEPTH];
  logic [ITER_W-1:0] iter;
  logic [5:0]       pad;
  logic [IDX_W-1:0] dig_idx;
  logic             out_valid;
  logic [7:0]       out_ch;
  logic             out_last;

  logic             neg_in;
  logic             dec_in;
  logic [31:0]      mag_in;
  logic [EXT_W-1:0] mag_ext;
  logic [3:0]       load_dig [DIGIT_BUFFER_DEPTH];
  logic [3:0]       adj      [DIGIT_BUFFER_DEPTH];
  logic [3:0]       dab_next [DIGIT_BUFFER_DEPTH];
  logic [IDX_W:0]   nd;
  logic [LEN_W-1:0] textlen;
  logic [5:0]       pad_next;
  logic [3:0]       cur_dig;
  logic [7:0]       dig_char;
  logic             out_free;

  // Operand decode at load
  always_comb begin
    neg_in  = (cmd == CMD_SDEC) && value[31];
    mag_in  = neg_in ? (~value + 32'd1) : value;
    dec_in  = !((cmd == CMD_HEXL) || (cmd == CMD_HEXU) || (cmd == CMD_OCT));
    mag_ext = {{(EXT_W-32){1'b0}}, mag_in};
    for (int i = 0; i < DIGIT_BUFFER_DEPTH; i++) begin
      if (cmd == CMD_OCT) begin
        load_dig[i] = {1'b0, mag_ext[3*i +: 3]};
      end else if (!dec_in) begin
        load_dig[i] = mag_ext[4*i +: 4];
      end else begin
        load_dig[i] = 4'd0;
      end
    end
  end

  // One shift-add-3 step over all digit positions
  always_comb begin
    for (int i = 0; i < DIGIT_BUFFER_DEPTH; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? (digits[i] + 4'd3) : digits[i];
    end
    dab_next[0] = {adj[0][2:0], mag[31]};
    for (int i = 1; i < DIGIT_BUFFER_DEPTH; i++) begin
      dab_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // Significant digit count (at least one) and padding
  always_comb begin
    nd = (IDX_W+1)'(1);
    for (int i = 1; i < DIGIT_BUFFER_DEPTH; i++) begin
      if (digits[i] != 4'd0) nd = (IDX_W+1)'(i + 1);
    end
    textlen  = LEN_W'(nd) + LEN_W'(neg);
    pad_next = (LEN_W'(width) > textlen) ? 6'(LEN_W'(width) - textlen) : 6'd0;
  end

  always_comb begin
    cur_dig  = digits[dig_idx];
    dig_char = (cur_dig < 4'd10) ? (CH_ZERO + 8'(cur_dig))
                                 : ((upper ? CH_UP_A : CH_LOW_A) + 8'(cur_dig - 4'd10));
  end

  assign out_free = !out_valid || text.ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag    <= mag_in;
      is_dec <= dec_in;
      upper  <= (cmd == CMD_HEXU);
      neg    <= neg_in;
      zf     <= zero_fill;
      width  <= (pad_width > 6'(WIDTH_LIMIT)) ? 6'(WIDTH_LIMIT) : pad_width;
      digits <= load_dig;
      iter   <= '0;
    end else if (ctl.dabble) begin
      digits <= dab_next;
      mag    <= {mag[30:0], 1'b0};
      iter   <= iter + 1'b1;
    end
    if (ctl.count) begin
      pad     <= pad_next;
      dig_idx <= IDX_W'(nd - 1'b1);
    end else if (ctl.emit_pad) begin
      pad <= pad - 6'd1;
    end else if (ctl.emit_digit) begin
      dig_idx <= dig_idx - 1'b1;
    end
  end

  // Output character register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_sign || ctl.emit_pad || ctl.emit_digit) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_sign) begin
      out_ch   <= CH_MINUS;
      out_last <= 1'b0;
    end else if (ctl.emit_pad) begin
      out_ch   <= zf ? CH_ZERO : CH_SPACE;
      out_last <= 1'b0;
    end else if (ctl.emit_digit) begin
      out_ch   <= dig_char;
      out_last <= (dig_idx == '0);
    end
  end

  assign text.valid = out_valid;
  assign text.ch    = out_ch;
  assign text.last  = out_last;

  always_comb begin
    status.is_dec     = is_dec;
    status.iter_last  = (iter == {ITER_W{1'b1}});
    status.neg        = neg;
    status.zf         = zf;
    status.pad_zero   = (pad == 6'd0);
    status.pad_last   = (pad == 6'd1);
    status.digit_last = (dig_idx == '0);
    status.out_free   = out_free;
  end

endmodule

/* hdl/i2a_ctrl.sv */
// Controller: sequences load, conversion, count and the character phases.
// Depends on i2a_pkg.
module i2a_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  i2a_pkg::dp_status_t status,
  output i2a_pkg::ctrl_cmd_t  ctl
);
  import i2a_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (!status.is_dec || status.iter_last) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        state_next = (status.neg && status.zf) ? ST_SIGN_A : ST_PAD;
      end
      ST_SIGN_A: begin
        if (status.out_free) state_next = ST_PAD;
      end
      ST_PAD: begin
        if (status.pad_zero || (status.out_free && status.pad_last)) begin
          state_next = (status.neg && !status.zf) ? ST_SIGN_B : ST_DIGITS;
        end
      end
      ST_SIGN_B: begin
        if (status.out_free) state_next = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (status.out_free && status.digit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        ctl.load   = item_valid;
      end
      ST_CONVERT: ctl.dabble     = status.is_dec;
      ST_COUNT:   ctl.count      = 1'b1;
      ST_SIGN_A:  ctl.emit_sign  = status.out_free;
      ST_PAD:     ctl.emit_pad   = status.out_free && !status.pad_zero;
      ST_SIGN_B:  ctl.emit_sign  = status.out_free;
      ST_DIGITS:  ctl.emit_digit = status.out_free;
      default: begin
        ctl        = '0;
        item_ready = 1'b0;
      end
    endcase
  end

endmodule
